// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/qkd_sift_pkg.sv =====
// ----------------------------------------------------------------------------
// qkd_sift_pkg
// types, constants and helpers for the basis sifting and error check block
// ----------------------------------------------------------------------------
package qkd_sift_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = 7;
    localparam int KEY_W         = 64;
    localparam int CFG_W         = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int PROD_W        = CNT_W + CFG_W;

    // one in 1/256 units
    localparam logic [CFG_W-1:0] FRAC_ONE = CFG_W'(256);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_FRACTION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = CFG_IDX_W'(1);

    // state encodings
    localparam logic [1:0] ST_ONE  = 2'd1;
    localparam logic [1:0] ST_PLUS = 2'd2;

    typedef struct packed {
        logic [1:0] sent_state;
        logic [2:0] spy_result;
        logic       recv_basis;
        logic [1:0] recv_state;
        logic       last;
    } sift_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] sender_key;
        logic [KEY_W-1:0] receiver_key;
        logic [CNT_W-1:0] key_length;
        logic [CNT_W-1:0] sifted_count;
        logic [CNT_W-1:0] spy_sifted_hits;
        logic [CNT_W-1:0] check_count;
        logic [CNT_W-1:0] check_errors;
        logic [CNT_W-1:0] key_errors;
        logic [CNT_W-1:0] spy_key_hits;
        logic             accepted;
    } sift_out_t;

    // stored particle record
    typedef struct packed {
        logic [1:0] recv_state;
        logic       recv_basis;
        logic [2:0] spy_result;
        logic [1:0] sent_state;
    } rec_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS1,
        S_CALC,
        S_PASS2,
        S_DONE
    } state_t;

    // one and plus give key bit 1
    function automatic logic state_bit(input logic [1:0] st);
        return (st == ST_ONE) || (st == ST_PLUS);
    endfunction

endpackage

// ===== sv/qkd_basis_sift_and_error_check.sv =====
// ----------------------------------------------------------------------------
// qkd_basis_sift_and_error_check
// buffers particle records in a 64-entry memory and, at the end of a batch,
// sifts them, counts check errors and builds both keys
// ----------------------------------------------------------------------------
//
//  channel | ports                          | moves
//  --------+--------------------------------+---------------------------------
//  input   | s_valid s_ready s_item         | one particle record per item
//  result  | m_valid m_ready m_item         | keys, counts and pass flag
//  config  | cfg_valid cfg_ready cfg_index  | check_fraction (0), error_limit (1)
//          | cfg_data                       |
//
//  a record that does not end a batch leaves the block ready for the next one
//  a batch of n records ends with two walks over the memory (one read port,
//  one record per cycle, registered read) and a calculation step between
//  them, after which the result is loaded into the output register
//  records are not taken during the walks; loading of the next batch starts
//  while the previous result still waits in the output register
//  reset is synchronous and active low and empties the buffer; the memory
//  itself is not cleared, only entries of the current batch are ever read

`include "assert_macros.svh"

module qkd_basis_sift_and_error_check (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // record input
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  qkd_sift_pkg::sift_in_t                  s_item,
    // result output
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output qkd_sift_pkg::sift_out_t                 m_item,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [qkd_sift_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qkd_sift_pkg::CFG_W-1:0]          cfg_data
);

    localparam int AW = qkd_sift_pkg::ADDR_W;
    localparam int CW = qkd_sift_pkg::CNT_W;
    localparam int KW = qkd_sift_pkg::KEY_W;
    localparam int FW = qkd_sift_pkg::CFG_W;
    localparam int PW = qkd_sift_pkg::PROD_W;

    // particle memory, one write port (load) and one read port (walks)
    qkd_sift_pkg::rec_t mem [qkd_sift_pkg::MAX_PARTICLES];
    qkd_sift_pkg::rec_t rd_data_reg;

    qkd_sift_pkg::state_t state_reg, state_next;

    logic [FW-1:0] check_fraction_reg;
    logic [FW-1:0] error_limit_reg;

    logic [CW-1:0] cnt_reg;       // records in the buffer
    logic [CW-1:0] rd_idx_reg;    // next address to read
    logic          rd_vld_reg;    // rd_data_reg holds a record of the walk

    logic [CW-1:0] sifted_reg, spy_sift_reg, checks_reg;
    logic [CW-1:0] seen_reg, kpos_reg, cerr_reg, kerr_reg, khits_reg;
    logic [KW-1:0] skey_reg, rkey_reg;

    qkd_sift_pkg::sift_out_t out_reg;
    logic                    out_vld_reg;

    // control for loading, walks and output
    logic load_acc;
    logic issue;
    logic walk_done;
    logic out_free;
    logic out_load;

    logic [CW-1:0]      cnt_inc;
    logic               batch_end;
    qkd_sift_pkg::rec_t wr_rec;
    logic               rec_sift;
    logic               rec_err;
    logic               rec_hit;
    logic [FW-1:0]      frac_clamp;
    logic [PW-1:0]      check_prod;
    logic [CW-1:0]      checks_calc;
    logic [CW-1:0]      keylen;
    logic [PW-1:0]      err_lhs;
    logic [PW-1:0]      err_rhs;

    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_item    = out_reg;

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign cnt_inc   = cnt_reg + CW'(1);
    assign batch_end = s_item.last || (cnt_inc == CW'(qkd_sift_pkg::MAX_PARTICLES));

    assign wr_rec.sent_state = s_item.sent_state;
    assign wr_rec.spy_result = s_item.spy_result;
    assign wr_rec.recv_basis = s_item.recv_basis;
    assign wr_rec.recv_state = s_item.recv_state;

    // basis match: receiver basis equals the basis bit of the sent state
    assign rec_sift = (rd_data_reg.recv_basis == rd_data_reg.sent_state[1]);
    assign rec_err  = (rd_data_reg.recv_state != rd_data_reg.sent_state);
    // spy codes above three never match a sent state
    assign rec_hit  = (rd_data_reg.spy_result == {1'b0, rd_data_reg.sent_state});

    // check count: floor(sifted * min(fraction, 256) / 256), at least one
    assign frac_clamp  = (check_fraction_reg > qkd_sift_pkg::FRAC_ONE) ?
                         qkd_sift_pkg::FRAC_ONE : check_fraction_reg;
    assign check_prod  = PW'(sifted_reg) * PW'(frac_clamp);
    assign checks_calc = (check_prod[PW-1:8] == '0) ? CW'(1) : CW'(check_prod[PW-1:8]);

    assign keylen  = (sifted_reg > checks_reg) ? (sifted_reg - checks_reg) : '0;
    // errors * 256 against limit * checks
    assign err_lhs = {1'b0, cerr_reg, 8'd0};
    assign err_rhs = PW'(error_limit_reg) * PW'(checks_reg);

    assign issue     = (rd_idx_reg < cnt_reg);
    assign walk_done = !issue && !rd_vld_reg;
    assign out_free  = !out_vld_reg || m_ready;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qkd_sift_pkg::S_LOAD: begin
                if (s_valid && batch_end) begin
                    state_next = qkd_sift_pkg::S_PASS1;
                end
            end
            qkd_sift_pkg::S_PASS1: begin
                if (walk_done) begin
                    state_next = qkd_sift_pkg::S_CALC;
                end
            end
            qkd_sift_pkg::S_CALC: begin
                state_next = qkd_sift_pkg::S_PASS2;
            end
            qkd_sift_pkg::S_PASS2: begin
                if (walk_done) begin
                    state_next = qkd_sift_pkg::S_DONE;
                end
            end
            qkd_sift_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = qkd_sift_pkg::S_LOAD;
                end
            end
            default: state_next = qkd_sift_pkg::S_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            qkd_sift_pkg::S_LOAD:  s_ready  = 1'b1;
            qkd_sift_pkg::S_DONE:  out_load = out_free;
            qkd_sift_pkg::S_PASS1,
            qkd_sift_pkg::S_CALC,
            qkd_sift_pkg::S_PASS2: begin
                s_ready  = 1'b0;
            end
            default: begin
                s_ready  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign load_acc = s_valid && s_ready;

    // ------------------------------------------------------------------
    // memory: write during load, registered read during the walks
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (load_acc) begin
            mem[cnt_reg[AW-1:0]] <= wr_rec;
        end
        rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= qkd_sift_pkg::S_LOAD;
            check_fraction_reg <= FW'(128);
            error_limit_reg    <= FW'(64);
            cnt_reg            <= '0;
            rd_idx_reg         <= '0;
            rd_vld_reg         <= 1'b0;
            out_vld_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                case (cfg_index)
                    qkd_sift_pkg::REG_CHECK_FRACTION: check_fraction_reg <= cfg_data;
                    qkd_sift_pkg::REG_ERROR_LIMIT:    error_limit_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (load_acc) begin
                cnt_reg <= cnt_inc;
            end else if (out_load) begin
                cnt_reg <= '0;
            end

            // read address walks 0..n-1 in each pass
            if (state_reg == qkd_sift_pkg::S_PASS1 || state_reg == qkd_sift_pkg::S_PASS2) begin
                rd_vld_reg <= issue;
                if (issue) begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
            end else begin
                rd_vld_reg <= 1'b0;
                rd_idx_reg <= '0;
            end

            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // counters and keys
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            qkd_sift_pkg::S_LOAD: begin
                sifted_reg   <= '0;
                spy_sift_reg <= '0;
            end
            qkd_sift_pkg::S_PASS1: begin
                if (rd_vld_reg && rec_sift) begin
                    sifted_reg <= sifted_reg + CW'(1);
                    if (rec_hit) begin
                        spy_sift_reg <= spy_sift_reg + CW'(1);
                    end
                end
            end
            qkd_sift_pkg::S_CALC: begin
                checks_reg <= checks_calc;
                seen_reg   <= '0;
                kpos_reg   <= '0;
                cerr_reg   <= '0;
                kerr_reg   <= '0;
                khits_reg  <= '0;
                skey_reg   <= '0;
                rkey_reg   <= '0;
            end
            qkd_sift_pkg::S_PASS2: begin
                if (rd_vld_reg && rec_sift) begin
                    seen_reg <= seen_reg + CW'(1);
                    if (seen_reg < checks_reg) begin
                        // published for checking
                        if (rec_err) begin
                            cerr_reg <= cerr_reg + CW'(1);
                        end
                    end else begin
                        if (rec_err) begin
                            kerr_reg <= kerr_reg + CW'(1);
                        end
                        if (rec_hit) begin
                            khits_reg <= khits_reg + CW'(1);
                        end
                        skey_reg[kpos_reg[AW-1:0]] <=
                            qkd_sift_pkg::state_bit(rd_data_reg.sent_state);
                        rkey_reg[kpos_reg[AW-1:0]] <=
                            qkd_sift_pkg::state_bit(rd_data_reg.recv_state);
                        kpos_reg <= kpos_reg + CW'(1);
                    end
                end
            end
            qkd_sift_pkg::S_DONE: begin
                if (out_load) begin
                    out_reg.sender_key      <= skey_reg;
                    out_reg.receiver_key    <= rkey_reg;
                    out_reg.key_length      <= keylen;
                    out_reg.sifted_count    <= sifted_reg;
                    out_reg.spy_sifted_hits <= spy_sift_reg;
                    out_reg.check_count     <= checks_reg;
                    out_reg.check_errors    <= cerr_reg;
                    out_reg.key_errors      <= kerr_reg;
                    out_reg.spy_key_hits    <= khits_reg;
                    out_reg.accepted        <= (err_lhs <= err_rhs);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_buf_not_full, state_reg == qkd_sift_pkg::S_LOAD,
        cnt_reg < CW'(qkd_sift_pkg::MAX_PARTICLES), "buffer full while loading")
    `ASSERT_NEXT(a_batch_walks, load_acc && batch_end,
        state_reg == qkd_sift_pkg::S_PASS1 && rd_idx_reg == '0, "batch end without walk")
    `ASSERT_IMPLY(a_check_nonzero, out_vld_reg,
        out_reg.check_count != '0 && out_reg.check_errors <= out_reg.check_count,
        "bad check count")
    `ASSERT_IMPLY(a_key_split, out_vld_reg && out_reg.sifted_count >= out_reg.check_count,
        out_reg.key_length + out_reg.check_count == out_reg.sifted_count,
        "key length does not split sifted count")
    `ASSERT_IMPLY(a_key_hits, out_vld_reg,
        out_reg.spy_key_hits <= out_reg.spy_sifted_hits, "key hits exceed sifted hits")

endmodule

// ===== dv/tb_qkd_basis_sift_and_error_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qkd_basis_sift_and_error_check
// self-checking bench for the basis sifting and error check block: a short
// table of hand-picked particle records, then random batches under a range of
// check fraction and error limit settings, with random idle cycles on the
// record side and random stalls on the result side; every result is compared
// field by field with a typed-in result or a local model of the sifting
// ----------------------------------------------------------------------------
module tb_qkd_basis_sift_and_error_check;

    localparam int MAXP = qkd_sift_pkg::MAX_PARTICLES;
    localparam int CW   = qkd_sift_pkg::CNT_W;
    localparam int FW   = qkd_sift_pkg::CFG_W;
    localparam int IW   = qkd_sift_pkg::CFG_IDX_W;
    localparam int KW   = qkd_sift_pkg::KEY_W;

    localparam int ITEMS_PER_PHASE = 92;
    localparam int NUM_PHASES      = 9;
    localparam int DRAIN_CYCLES    = 2 * MAXP + 16;
    localparam int WATCHDOG_LIMIT  = 3000;

    // register indexes the block has no register for
    localparam logic [IW-1:0] REG_SPARE_A = IW'(2);
    localparam logic [IW-1:0] REG_SPARE_B = IW'(3);

    typedef struct packed {
        qkd_sift_pkg::sift_in_t  rec;
        logic                    typed;
        qkd_sift_pkg::sift_out_t res;
    } dir_row_t;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    qkd_sift_pkg::sift_in_t  s_item    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    qkd_sift_pkg::sift_out_t m_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IW-1:0]           cfg_index = '0;
    logic [FW-1:0]           cfg_data  = '0;

    // local copy of the block's settings and of the batch being loaded
    logic [FW-1:0]          frac_reg  = FW'(128);
    logic [FW-1:0]          limit_reg = FW'(64);
    qkd_sift_pkg::sift_in_t batch_recs [MAXP];
    int                     batch_len = 0;

    qkd_sift_pkg::sift_out_t pending_results[$];
    dir_row_t                dir_rows[$];
    int                      mismatch_cnt = 0;
    int                      items_sent   = 0;
    int                      quiet_cycles = 0;
    bit                      tx_calm      = 1'b0;
    bit                      rx_calm      = 1'b0;

    qkd_basis_sift_and_error_check uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sift the loaded batch: check records first, the rest become key bits
    function automatic qkd_sift_pkg::sift_out_t sift_batch();
        qkd_sift_pkg::sift_out_t res;
        qkd_sift_pkg::sift_in_t  r;
        int        sifted, spy_hits, frac, checks, keylen;
        int        seen, kpos, cerr, kerr, khits;
        res = '0;
        sifted = 0;
        spy_hits = 0;
        for (int i = 0; i < batch_len; i++) begin
            r = batch_recs[i];
            if (r.recv_basis == r.sent_state[1]) begin
                sifted++;
                if (r.spy_result == {1'b0, r.sent_state}) spy_hits++;
            end
        end
        frac = (frac_reg > qkd_sift_pkg::FRAC_ONE) ? int'(qkd_sift_pkg::FRAC_ONE)
                                                   : int'(frac_reg);
        checks = (sifted * frac) >> 8;
        if (checks == 0) checks = 1;
        keylen = (sifted > checks) ? sifted - checks : 0;
        seen = 0;
        kpos = 0;
        cerr = 0;
        kerr = 0;
        khits = 0;
        for (int i = 0; i < batch_len; i++) begin
            r = batch_recs[i];
            if (r.recv_basis == r.sent_state[1]) begin
                seen++;
                if (seen <= checks) begin
                    if (r.recv_state != r.sent_state) cerr++;
                end else begin
                    if (r.recv_state != r.sent_state) kerr++;
                    if (r.spy_result == {1'b0, r.sent_state}) khits++;
                    // one (01) and plus (10) carry key bit 1
                    res.sender_key[kpos]   = r.sent_state[1] ^ r.sent_state[0];
                    res.receiver_key[kpos] = r.recv_state[1] ^ r.recv_state[0];
                    kpos++;
                end
            end
        end
        res.key_length      = CW'(keylen);
        res.sifted_count    = CW'(sifted);
        res.spy_sifted_hits = CW'(spy_hits);
        res.check_count     = CW'(checks);
        res.check_errors    = CW'(cerr);
        res.key_errors      = CW'(kerr);
        res.spy_key_hits    = CW'(khits);
        res.accepted        = (cerr * 256 <= int'(limit_reg) * checks);
        return res;
    endfunction

    function automatic qkd_sift_pkg::sift_out_t known_res(input int klen, sifted, spy_h,
                                                          chk, cerr, kerr, khits,
                                                          input bit acc);
        qkd_sift_pkg::sift_out_t res;
        res = '0;
        res.key_length      = CW'(klen);
        res.sifted_count    = CW'(sifted);
        res.spy_sifted_hits = CW'(spy_h);
        res.check_count     = CW'(chk);
        res.check_errors    = CW'(cerr);
        res.key_errors      = CW'(kerr);
        res.spy_key_hits    = CW'(khits);
        res.accepted        = acc;
        return res;
    endfunction

    function automatic dir_row_t row(input int sent, spy, basis, recv, last_bit);
        dir_row_t d;
        d = '0;
        d.rec.sent_state = 2'(sent);
        d.rec.spy_result = 3'(spy);
        d.rec.recv_basis = 1'(basis);
        d.rec.recv_state = 2'(recv);
        d.rec.last       = 1'(last_bit);
        return d;
    endfunction

    function automatic dir_row_t row_known(input int sent, spy, basis, recv,
                                           input qkd_sift_pkg::sift_out_t res);
        dir_row_t d;
        d = row(sent, spy, basis, recv, 1);
        d.typed = 1'b1;
        d.res   = res;
        return d;
    endfunction

    // mostly matching bases so batches sift well; err_pct sets the noise level
    function automatic qkd_sift_pkg::sift_in_t rand_record(input int err_pct,
                                                          input logic last_bit);
        qkd_sift_pkg::sift_in_t r;
        r.sent_state = 2'($urandom_range(0, 3));
        r.spy_result = 3'($urandom_range(0, 7));
        r.recv_basis = ($urandom_range(0, 3) != 0) ? r.sent_state[1]
                                                   : 1'($urandom_range(0, 1));
        r.recv_state = ($urandom_range(0, 99) < err_pct) ? 2'($urandom_range(0, 3))
                                                         : r.sent_state;
        r.last       = last_bit;
        return r;
    endfunction

    // record one accepted item; a batch ends on last or a full buffer
    task automatic load_record(input qkd_sift_pkg::sift_in_t it, input logic typed,
                               input qkd_sift_pkg::sift_out_t res);
        batch_recs[batch_len] = it;
        batch_len++;
        items_sent++;
        if (it.last || batch_len == MAXP) begin
            pending_results.push_back(typed ? res : sift_batch());
            batch_len = 0;
        end
    endtask

    task automatic push_record(input qkd_sift_pkg::sift_in_t it, input logic typed,
                               input qkd_sift_pkg::sift_out_t res);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        load_record(it, typed, res);
    endtask

    // leaves cfg_valid high so back-to-back writes follow without a gap
    task automatic write_reg(input logic [IW-1:0] idx, input logic [FW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == qkd_sift_pkg::REG_CHECK_FRACTION) frac_reg = val;
        else if (idx == qkd_sift_pkg::REG_ERROR_LIMIT) limit_reg = val;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_batch(input int len, input bit noisy);
        int                     pct;
        logic                   last_bit;
        qkd_sift_pkg::sift_in_t it;
        case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 5;
            2:       pct = 30;
            default: pct = 100;
        endcase
        tx_calm = ($urandom_range(0, 4) == 0);
        rx_calm = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < len; k++) begin
            if (noisy) last_bit = ($urandom_range(0, 7) == 0);
            else last_bit = (k == len - 1) &&
                            !(len == MAXP && $urandom_range(0, 1) == 1);
            it = rand_record(pct, last_bit);
            push_record(it, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [KW-1:0] want,
                               input logic [KW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // result side: compare each accepted item with the oldest expectation
    always @(posedge aclk) begin : result_mon
        qkd_sift_pkg::sift_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_item);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("sender_key", want.sender_key, m_item.sender_key);
                check_field("receiver_key", want.receiver_key, m_item.receiver_key);
                check_field("key_length", KW'(want.key_length),
                            KW'(m_item.key_length));
                check_field("sifted_count", KW'(want.sifted_count),
                            KW'(m_item.sifted_count));
                check_field("spy_sifted_hits", KW'(want.spy_sifted_hits),
                            KW'(m_item.spy_sifted_hits));
                check_field("check_count", KW'(want.check_count),
                            KW'(m_item.check_count));
                check_field("check_errors", KW'(want.check_errors),
                            KW'(m_item.check_errors));
                check_field("key_errors", KW'(want.key_errors),
                            KW'(m_item.key_errors));
                check_field("spy_key_hits", KW'(want.spy_key_hits),
                            KW'(m_item.spy_key_hits));
                check_field("accepted", KW'(want.accepted), KW'(m_item.accepted));
            end
        end
    end

    // result side stalls: either held ready, or a wait once a result shows up
    initial begin : result_ready
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = $urandom_range(0, 11);
            if (rx_calm || stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (stall - 1) @(posedge aclk);
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // ends a hung run: no item on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        logic [FW-1:0] frac_v, limit_v;
        int            phase_start, kind;
        // reset values: fraction 128, limit 64
        // single zero, not intercepted, sifted: only a check record
        dir_rows.push_back(row_known(0, 4, 0, 0, known_res(0, 1, 0, 1, 0, 0, 0, 1)));
        // plus measured rectilinear: nothing sifted, check count stays 1
        dir_rows.push_back(row_known(2, 4, 0, 0, known_res(0, 0, 0, 1, 0, 0, 0, 1)));
        // one, spy hit, read as minus: one check error, batch rejected
        dir_rows.push_back(row_known(1, 1, 0, 3, known_res(0, 1, 1, 1, 1, 0, 0, 0)));
        // all fields at their top: spy result 7 never hits
        dir_rows.push_back(row_known(3, 7, 1, 3, known_res(0, 1, 0, 1, 0, 0, 0, 1)));
        // minus in the wrong basis, spy result 5
        dir_rows.push_back(row_known(3, 5, 0, 2, known_res(0, 0, 0, 1, 0, 0, 0, 1)));
        // four sifted records, two become key bits
        dir_rows.push_back(row(0, 0, 0, 0, 0));
        dir_rows.push_back(row(1, 6, 0, 0, 0));
        dir_rows.push_back(row(2, 2, 1, 2, 0));
        dir_rows.push_back(row(3, 3, 1, 1, 1));
        // mismatched bases mixed in
        dir_rows.push_back(row(0, 0, 1, 0, 0));
        dir_rows.push_back(row(1, 3, 1, 2, 0));
        dir_rows.push_back(row(2, 1, 1, 2, 0));
        dir_rows.push_back(row(1, 1, 0, 1, 1));
        // clean batch of six with every state
        dir_rows.push_back(row(1, 4, 0, 1, 0));
        dir_rows.push_back(row(2, 2, 1, 2, 0));
        dir_rows.push_back(row(0, 0, 0, 0, 0));
        dir_rows.push_back(row(3, 3, 1, 3, 0));
        dir_rows.push_back(row(1, 1, 0, 1, 0));
        dir_rows.push_back(row(2, 4, 1, 2, 1));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            push_record(dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].res);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // settings change only with the block drained
            s_valid <= 1'b0;
            wait_idle();
            case (p)
                0: begin
                    frac_v  = '0;
                    limit_v = '0;
                end
                1: begin
                    frac_v  = qkd_sift_pkg::FRAC_ONE;
                    limit_v = qkd_sift_pkg::FRAC_ONE;
                end
                2: begin
                    frac_v  = '1;
                    limit_v = '1;
                end
                3: begin
                    frac_v  = qkd_sift_pkg::FRAC_ONE + 1'b1;
                    limit_v = '0;
                end
                4: begin
                    frac_v  = FW'(1);
                    limit_v = qkd_sift_pkg::FRAC_ONE - 1'b1;
                end
                default: begin
                    frac_v  = FW'($urandom_range(0, 511));
                    limit_v = FW'($urandom_range(0, 511));
                end
            endcase
            // writes to unused indexes must change nothing
            write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                      FW'($urandom_range(0, 511)));
            if ($urandom_range(0, 1) == 1) begin
                write_reg(qkd_sift_pkg::REG_CHECK_FRACTION, frac_v);
                write_reg(qkd_sift_pkg::REG_ERROR_LIMIT, limit_v);
            end else begin
                write_reg(qkd_sift_pkg::REG_ERROR_LIMIT, limit_v);
                write_reg(qkd_sift_pkg::REG_CHECK_FRACTION, frac_v);
            end
            write_reg(REG_SPARE_B, p[0] ? '1 : '0);
            cfg_valid <= 1'b0;

            phase_start = items_sent;
            // some phases open with a batch that fills the buffer
            if (p % 2 == 0) send_batch(MAXP, 1'b0);
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 99);
                if (kind < 75) send_batch($urandom_range(1, 12), 1'b0);
                else if (kind < 79) send_batch(MAXP, 1'b0);
                else send_batch($urandom_range(1, 20), 1'b1);
            end
            // close any open batch so the phase ends drained
            if (batch_len != 0) push_record(rand_record(10, 1'b1), 1'b0, '0);
        end

        s_valid <= 1'b0;
        wait_idle();
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
